/* rtl/bsle_pkg.sv */
// Shared types and constants of the bounded sorted list engine.
`default_nettype none
package bsle_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned COUNT_OUT_W = 11;

  typedef enum logic [2:0] {
    OP_INS_HEAD   = 3'd0,
    OP_INS_TAIL   = 3'd1,
    OP_INS_SORTED = 3'd2,
    OP_REM_HEAD   = 3'd3,
    OP_REM_TAIL   = 3'd4,
    OP_REM_VALUE  = 3'd5,
    OP_MEMBER     = 3'd6
  } opcode_t;

  // Test applied to each stored element during a walk.
  typedef enum logic [1:0] {
    PRED_NEVER  = 2'd0,
    PRED_FIRST  = 2'd1,
    PRED_NOT_LT = 2'd2,
    PRED_EQ     = 2'd3
  } pred_t;

  typedef enum logic [1:0] {
    KIND_INS = 2'd0,
    KIND_REM = 2'd1,
    KIND_MEM = 2'd2
  } walk_kind_t;

  typedef struct packed {
    logic                          success;
    logic signed [DATA_W-1:0]      value_out;
    logic [COUNT_OUT_W-1:0]        entry_count;
    logic                          is_empty;
  } result_t;

endpackage
`default_nettype wire

/* rtl/bsle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bsle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/bsle_ctrl.sv */
// Sequencer that walks the list memory to insert, remove and search elements.
`default_nettype none
module bsle_ctrl #(
  parameter int unsigned CAPACITY = bsle_pkg::CAPACITY_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [2:0]                      opcode,
  input  wire logic signed [bsle_pkg::DATA_W-1:0] value_in,
  output logic                                 idle,
  output logic                                 res_valid,
  input  wire logic                            res_take,
  output bsle_pkg::result_t                    res,
  output logic                                 mem_rd_en,
  output logic [$clog2(CAPACITY)-1:0]          mem_rd_addr,
  input  wire logic [bsle_pkg::DATA_W-1:0]     mem_rd_data,
  output logic                                 mem_wr_en,
  output logic [$clog2(CAPACITY)-1:0]          mem_wr_addr,
  output logic [bsle_pkg::DATA_W-1:0]          mem_wr_data
);
  import bsle_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = CW + COUNT_OUT_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_WALK    = 4'b0010,
    S_INS_END = 4'b0100,
    S_FIN     = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [2:0]          op_r, op_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;
  pred_t               pred_r, pred_nxt;
  walk_kind_t          kind_r, kind_nxt;
  logic [CW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                p_vld_r, p_vld_nxt;
  logic [CW-1:0]       p_idx_r, p_idx_nxt;
  logic                found_r, found_nxt;
  logic                ok_r, ok_nxt;
  logic [DATA_W-1:0]   carry_r, carry_nxt;
  logic [DATA_W-1:0]   removed_r, removed_nxt;

  logic                hit;
  logic                full;
  logic                last;
  logic [EW-1:0]       cnt_ext;

  always_comb begin
    case (pred_r)
      PRED_FIRST:  hit = 1'b1;
      PRED_NOT_LT: hit = !($signed(mem_rd_data) < $signed(val_r));
      PRED_EQ:     hit = (mem_rd_data == val_r);
      default:     hit = 1'b0;
    endcase
  end

  assign full = (cnt_r >= CAP_C);
  assign last = (p_idx_r == cnt_r - ONE_C);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    pred_nxt    = pred_r;
    kind_nxt    = kind_r;
    rd_idx_nxt  = rd_idx_r;
    p_vld_nxt   = 1'b0;
    p_idx_nxt   = rd_idx_r;
    found_nxt   = found_r;
    ok_nxt      = ok_r;
    carry_nxt   = carry_r;
    removed_nxt = removed_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = rd_idx_r[AW-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = p_idx_r[AW-1:0];
    mem_wr_data = carry_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt      = opcode;
          val_nxt     = value_in;
          found_nxt   = 1'b0;
          ok_nxt      = 1'b0;
          removed_nxt = '0;
          rd_idx_nxt  = '0;
          pred_nxt    = PRED_NEVER;
          kind_nxt    = KIND_INS;
          state_nxt   = S_FIN;
          case (opcode)
            OP_INS_HEAD, OP_INS_SORTED: begin
              pred_nxt = (opcode == OP_INS_HEAD) ? PRED_FIRST : PRED_NOT_LT;
              if (!full) begin
                state_nxt = (cnt_r == '0) ? S_INS_END : S_WALK;
              end
            end
            OP_INS_TAIL: begin
              if (!full) begin
                state_nxt = S_INS_END;
              end
            end
            OP_REM_HEAD, OP_REM_TAIL, OP_REM_VALUE, OP_MEMBER: begin
              kind_nxt = (opcode == OP_MEMBER) ? KIND_MEM : KIND_REM;
              pred_nxt = (opcode == OP_REM_HEAD || opcode == OP_REM_TAIL) ?
                         PRED_FIRST : PRED_EQ;
              // Tail removal reads just the last element.
              if (opcode == OP_REM_TAIL) begin
                rd_idx_nxt = cnt_r - ONE_C;
              end
              if (cnt_r != '0) begin
                state_nxt = S_WALK;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_WALK: begin
        // Reads run one element ahead of the data being processed.
        if (rd_idx_r < cnt_r) begin
          mem_rd_en  = 1'b1;
          rd_idx_nxt = rd_idx_r + ONE_C;
          p_vld_nxt  = 1'b1;
        end
        if (p_vld_r) begin
          case (kind_r)
            KIND_INS: begin
              if (found_r) begin
                mem_wr_en   = 1'b1;
                mem_wr_data = carry_r;
                carry_nxt   = mem_rd_data;
              end else if (hit) begin
                mem_wr_en   = 1'b1;
                mem_wr_data = val_r;
                carry_nxt   = mem_rd_data;
                found_nxt   = 1'b1;
              end
              if (last) begin
                state_nxt = S_INS_END;
              end
            end
            KIND_REM: begin
              if (found_r) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(p_idx_r - ONE_C);
                mem_wr_data = mem_rd_data;
              end else if (hit) begin
                found_nxt   = 1'b1;
                removed_nxt = mem_rd_data;
              end
              if (last) begin
                if (found_nxt) begin
                  cnt_nxt = cnt_r - ONE_C;
                end
                ok_nxt    = found_nxt;
                state_nxt = S_FIN;
              end
            end
            default: begin
              if (hit || last) begin
                ok_nxt    = hit;
                state_nxt = S_FIN;
              end
            end
          endcase
        end
      end

      S_INS_END: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = cnt_r[AW-1:0];
        mem_wr_data = found_r ? carry_r : val_r;
        cnt_nxt     = cnt_r + ONE_C;
        ok_nxt      = 1'b1;
        state_nxt   = S_FIN;
      end

      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      p_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      p_vld_r <= p_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    pred_r    <= pred_nxt;
    kind_r    <= kind_nxt;
    rd_idx_r  <= rd_idx_nxt;
    p_idx_r   <= p_idx_nxt;
    found_r   <= found_nxt;
    ok_r      <= ok_nxt;
    carry_r   <= carry_nxt;
    removed_r <= removed_nxt;
  end

  assign cnt_ext = EW'(cnt_r);
  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);

  always_comb begin
    res.success     = ok_r;
    res.value_out   = (ok_r && (op_r == OP_REM_HEAD || op_r == OP_REM_TAIL)) ?
                      removed_r : '0;
    res.entry_count = cnt_ext[COUNT_OUT_W-1:0];
    res.is_empty    = (cnt_r == '0);
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C) else $error("element count beyond capacity");
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN) |-> !mem_wr_en)
    else $error("memory written outside a walk");
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS_END |=> cnt_r == $past(cnt_r) + ONE_C)
    else $error("insert did not grow the list");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == S_IDLE) else $error("item started while busy");
`endif

endmodule
`default_nettype wire

/* rtl/bounded_sorted_list_engine_unit.sv */
// Top level of the bounded sorted list engine: handshakes, result register, list memory.
//
//  channel | signals                                    | direction
//  in      | in_valid in_ready in_opcode in_value_in     | item in
//  out     | out_valid out_ready out_success             | result out
//          | out_value_out out_entry_count out_is_empty   |
//
// After the accepting cycle a tail insert writes straight to the end of the list and a
// tail removal reads only the last element; head and sorted insert, head removal and
// removal by value walk the whole list, and a membership test stops at the first match;
// a refused insert or removal goes straight to the result. One element passes per cycle
// through the list memory's single read port. Reset (synchronous, active low)
// empties the list at once; the memory itself is not cleared. A stalled result
// waits in the output register while the next item is accepted and walked.
`default_nettype none
module bounded_sorted_list_engine_unit #(
  parameter int unsigned CAPACITY = bsle_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [2:0]                          in_opcode,
  input  wire logic signed [bsle_pkg::DATA_W-1:0]  in_value_in,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_success,
  output logic signed [bsle_pkg::DATA_W-1:0]       out_value_out,
  output logic [bsle_pkg::COUNT_OUT_W-1:0]         out_entry_count,
  output logic                                     out_is_empty
);
  import bsle_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  logic              idle;
  logic              res_valid;
  logic              res_take;
  result_t           res;
  result_t           out_r;
  logic              out_valid_r;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [DATA_W-1:0] rd_data, wr_data;

  bsle_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bsle_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_valid && in_ready),
    .opcode      (in_opcode),
    .value_in    (in_value_in),
    .idle        (idle),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .mem_rd_en   (rd_en),
    .mem_rd_addr (rd_addr),
    .mem_rd_data (rd_data),
    .mem_wr_en   (wr_en),
    .mem_wr_addr (wr_addr),
    .mem_wr_data (wr_data)
  );

  assign in_ready = idle;
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_success     = out_r.success;
  assign out_value_out   = out_r.value_out;
  assign out_entry_count = out_r.entry_count;
  assign out_is_empty    = out_r.is_empty;

endmodule
`default_nettype wire

/* bench/bsle_checker.sv */
// Checker that watches both channels of the list engine, predicts each result and compares it.
module bsle_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic [2:0]                             in_opcode,
  input  logic signed [bsle_pkg::DATA_W-1:0]     in_value_in,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic                                   out_success,
  input  logic signed [bsle_pkg::DATA_W-1:0]     out_value_out,
  input  logic [bsle_pkg::COUNT_OUT_W-1:0]       out_entry_count,
  input  logic                                   out_is_empty,
  output int                                     fail_count,
  output int                                     pending
);
  import bsle_pkg::*;

  localparam int unsigned CAP = CAPACITY_DEF;

  logic signed [DATA_W-1:0] shadow_list[$];
  result_t expected_results[$];

  // Applies one item to the shadow list and returns the result it should give.
  function automatic result_t apply_op(logic [2:0] op, logic signed [DATA_W-1:0] v);
    result_t r;
    int pos;
    bit full;
    r = '0;
    full = shadow_list.size() >= CAP;
    case (op)
      OP_INS_HEAD: if (!full) begin
        shadow_list.push_front(v);
        r.success = 1'b1;
      end
      OP_INS_TAIL: if (!full) begin
        shadow_list.push_back(v);
        r.success = 1'b1;
      end
      OP_INS_SORTED: if (!full) begin
        pos = 0;
        while (pos < shadow_list.size() && shadow_list[pos] < v) pos++;
        shadow_list.insert(pos, v);
        r.success = 1'b1;
      end
      OP_REM_HEAD: if (shadow_list.size() > 0) begin
        r.value_out = shadow_list.pop_front();
        r.success = 1'b1;
      end
      OP_REM_TAIL: if (shadow_list.size() > 0) begin
        r.value_out = shadow_list.pop_back();
        r.success = 1'b1;
      end
      OP_REM_VALUE, OP_MEMBER: begin
        for (pos = 0; pos < shadow_list.size(); pos++)
          if (shadow_list[pos] == v) break;
        if (pos < shadow_list.size()) begin
          r.success = 1'b1;
          if (op == OP_REM_VALUE) shadow_list.delete(pos);
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_OUT_W'(shadow_list.size());
    r.is_empty = shadow_list.size() == 0;
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n) begin
      if (in_valid && in_ready) expected_results.push_back(apply_op(in_opcode, in_value_in));
      if (out_valid && out_ready) begin
        got = {out_success, out_value_out, out_entry_count, out_is_empty};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p, actual %p", want, got);
          end
        end
      end
    end
  end
endmodule

/* bench/tb_bounded_sorted_list_engine_unit.sv */
// Testbench top: drives items into the list engine and gives the verdict.
module tb_bounded_sorted_list_engine_unit;
  import bsle_pkg::*;

  // Opcode with no operation behind it.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_opcode = '0;
  logic signed [DATA_W-1:0] in_value_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_success;
  logic signed [DATA_W-1:0] out_value_out;
  logic [COUNT_OUT_W-1:0] out_entry_count;
  logic out_is_empty;
  int fail_count;
  int pending;
  int cycle_count = 0;
  bit quiet_phase = 1'b0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_sorted_list_engine_unit DUT (.*);

  bsle_checker checker_i (.*);

  // Small value pool so that searches and removals by value often hit.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  // Valid stays high from one item to the next unless an idle cycle comes between.
  task automatic send(logic [2:0] op, logic signed [DATA_W-1:0] v);
    while (!quiet_phase && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_value_in <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver: random stalls, with a long hold-off while the sender keeps going.
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= quiet_phase || $urandom_range(0, 99) >= 12;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int n;
    int k;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: empty removals, extremes, every opcode, duplicates, unused opcode.
    send(OP_REM_HEAD, 0);
    send(OP_REM_TAIL, 0);
    send(OP_REM_VALUE, 5);
    send(OP_MEMBER, 5);
    send(OP_UNUSED, -1);
    send(OP_INS_SORTED, 32'sh7fffffff);
    send(OP_INS_SORTED, 32'sh80000000);
    send(OP_INS_SORTED, 0);
    send(OP_INS_SORTED, 0);
    send(OP_INS_HEAD, -1);
    send(OP_INS_TAIL, 32'sh55555555);
    send(OP_INS_TAIL, 32'shaaaaaaaa);
    send(OP_MEMBER, 0);
    send(OP_MEMBER, 3);
    send(OP_REM_VALUE, 0);
    send(OP_REM_VALUE, 3);
    send(OP_UNUSED, 32'sh7fffffff);
    send(OP_REM_HEAD, 0);
    send(OP_REM_TAIL, 0);
    send(OP_INS_SORTED, -1);
    // Hold off the receiver so the block backs up and stalls its input.
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (k = 0; k < 6; k++) send(OP_INS_TAIL, pick_value());
    join
    // Random part; a quiet stretch in the middle.
    for (n = 0; n < 554; n++) begin
      quiet_phase = n >= 250 && n < 350;
      k = $urandom_range(0, 99);
      if (k < 40) send(3'($urandom_range(0, 2)), pick_value());
      else if (k < 95) send(3'($urandom_range(3, 6)), pick_value());
      else send(OP_UNUSED, $urandom());
    end
    quiet_phase = 1'b0;
    in_valid <= 1'b0;
    while (pending > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

/* filelist.f */
rtl/bsle_pkg.sv
rtl/bsle_ram.sv
rtl/bsle_ctrl.sv
rtl/bounded_sorted_list_engine_unit.sv
bench/bsle_checker.sv
bench/tb_bounded_sorted_list_engine_unit.sv
